// ===== design/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk and disabled while in reset.
`define PPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk and disabled while in reset.
`define PPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPS_ASSERT_IMP(lbl, ante, cons, msg)
`define PPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/pps_pkg.sv =====
// Package with sizes, codes and shared types of the priority scheduler.
package pps_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TIME_BITS = 16;
    localparam int PRIO_BITS = 8;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    // Widths of the port fields.
    localparam int FIELD_SLOT_W = 4;
    localparam int FIELD_TIME_W = 16;
    localparam int FIELD_PRIO_W = 8;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_TAT,
        ST_OUT
    } t_state;

    // Best candidate so far, handed from cell to cell.
    typedef struct packed {
        logic                 have;
        logic [IDX_W-1:0]     idx;
        logic [PRIO_BITS-1:0] prio;
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] burst;
        logic [TIME_BITS-1:0] rem;
    } t_cand;

    // Write of one task entry.
    typedef struct packed {
        logic                    en;
        logic [FIELD_SLOT_W-1:0] slot;
        logic [TIME_BITS-1:0]    arrival;
        logic [PRIO_BITS-1:0]    prio;
        logic [TIME_BITS-1:0]    burst;
    } t_load;

    // One unit of service granted to the winning slot.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_upd;

endpackage

// ===== design/pps_cell.sv =====
// One task slot: holds its entry and merges itself into the passing candidate.
module pps_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pps_pkg::IDX_W-1:0]     i_idx,
    input  logic                          i_wr,
    input  pps_pkg::t_load                i_load,
    input  pps_pkg::t_upd                 i_upd,
    input  logic [pps_pkg::TIME_BITS-1:0] i_now,
    input  logic                          i_go,
    input  pps_pkg::t_cand                i_cand,
    output logic                          o_go,
    output pps_pkg::t_cand                o_cand,
    output logic                          o_pending
);

    logic                          r_valid;
    logic                          r_done;
    logic [pps_pkg::TIME_BITS-1:0] r_arrival;
    logic [pps_pkg::PRIO_BITS-1:0] r_prio;
    logic [pps_pkg::TIME_BITS-1:0] r_burst;
    logic [pps_pkg::TIME_BITS-1:0] r_rem;
    logic                          r_go;
    pps_pkg::t_cand                r_cand;
    pps_pkg::t_cand                n_cand;

    logic hit;
    logic eligible;
    logic better;

    assign hit      = i_upd.en && (i_upd.idx == i_idx);
    assign eligible = r_valid && !r_done && (r_arrival <= i_now);
    assign better   = !i_cand.have || (r_prio < i_cand.prio) ||
                      ((r_prio == i_cand.prio) && (r_arrival < i_cand.arrival));

    always_comb begin
        n_cand = i_cand;
        if (eligible && better) begin
            n_cand.have    = 1'b1;
            n_cand.idx     = i_idx;
            n_cand.prio    = r_prio;
            n_cand.arrival = r_arrival;
            n_cand.burst   = r_burst;
            n_cand.rem     = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_go <= i_go;
            if (i_wr) begin
                r_valid <= 1'b1;
                r_done  <= 1'b0;
            end else if (hit && (r_rem <= pps_pkg::TIME_BITS'(1))) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        if (i_wr) begin
            r_arrival <= i_load.arrival;
            r_prio    <= i_load.prio;
            r_burst   <= i_load.burst;
            r_rem     <= i_load.burst;
        end else if (hit && (r_rem != '0)) begin
            r_rem <= r_rem - pps_pkg::TIME_BITS'(1);
        end
    end

    assign o_go      = r_go;
    assign o_cand    = r_cand;
    assign o_pending = r_valid && !r_done;

endmodule

// ===== design/pps_chain.sv =====
// Row of task cells through which the selection candidate travels.
module pps_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pps_pkg::t_load                i_load,
    input  pps_pkg::t_upd                 i_upd,
    input  logic [pps_pkg::TIME_BITS-1:0] i_now,
    input  logic                          i_go,
    output logic                          o_go,
    output pps_pkg::t_cand                o_cand,
    output logic                          o_any_pending
);

    logic                   go_link   [pps_pkg::MAX_TASKS+1];
    pps_pkg::t_cand         cand_link [pps_pkg::MAX_TASKS+1];
    logic [pps_pkg::MAX_TASKS-1:0] pending;

    // The head of the row sees an empty candidate.
    assign go_link[0]   = i_go;
    assign cand_link[0] = '0;

    for (genvar k = 0; k < pps_pkg::MAX_TASKS; k++) begin : g_cell
        logic wr;
        assign wr = i_load.en && (32'(i_load.slot) == 32'(k));

        pps_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (pps_pkg::IDX_W'(k)),
            .i_wr      (wr),
            .i_load    (i_load),
            .i_upd     (i_upd),
            .i_now     (i_now),
            .i_go      (go_link[k]),
            .i_cand    (cand_link[k]),
            .o_go      (go_link[k+1]),
            .o_cand    (cand_link[k+1]),
            .o_pending (pending[k])
        );
    end

    assign o_go          = go_link[pps_pkg::MAX_TASKS];
    assign o_cand        = cand_link[pps_pkg::MAX_TASKS];
    assign o_any_pending = |pending;

endmodule

// ===== design/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler: command port, control and results.
//
//  Channel   Ports                                              Handshake
//  --------  -------------------------------------------------  -------------------------
//  command   i_command i_slot i_arrival i_prio i_burst          start high, busy low
//  result    o_load_error o_idle o_running_slot o_finished      o_strobe for one cycle
//            o_finish_time o_turnaround o_waiting o_all_done
//            o_tick_time
//
// A load beat passes the LOAD state, which sets the result registers and the strobe.
// A tick beat walks the candidate through the row of slot cells one cell per cycle;
// then the SCAN state serves the winner and advances time, the TAT state forms the
// turnaround, and the OUT state forms the waiting time and the result registers.
// Reset (i_rst_n low at a clock edge) empties every slot and sets time to zero.
// The receiver cannot stall; busy stays high from acceptance until the result is set.
//
// Every slot lives in its own cell. On a tick an empty candidate enters the first cell
// and each cell replaces it with its own entry when that entry is eligible (loaded, not
// finished, arrived by the current time) and beats the candidate: lower priority value,
// then earlier arrival. Strict comparisons keep the lower slot on a full tie, since lower
// slots are visited first. The candidate leaving the last cell is the winner.
`include "assert_macros.svh"

module preemptive_priority_scheduler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_command,
    input  logic [pps_pkg::FIELD_SLOT_W-1:0]     i_slot,
    input  logic [pps_pkg::FIELD_TIME_W-1:0]     i_arrival,
    input  logic [pps_pkg::FIELD_PRIO_W-1:0]     i_prio,
    input  logic [pps_pkg::FIELD_TIME_W-1:0]     i_burst,
    output logic                                 o_strobe,
    output logic                                 o_load_error,
    output logic                                 o_idle,
    output logic [pps_pkg::FIELD_SLOT_W-1:0]     o_running_slot,
    output logic                                 o_finished,
    output logic [pps_pkg::FIELD_TIME_W-1:0]     o_finish_time,
    output logic [pps_pkg::FIELD_TIME_W-1:0]     o_turnaround,
    output logic [pps_pkg::FIELD_TIME_W-1:0]     o_waiting,
    output logic                                 o_all_done,
    output logic [pps_pkg::FIELD_TIME_W-1:0]     o_tick_time
);

    pps_pkg::t_state r_state;
    pps_pkg::t_state n_state;

    // Scheduler time and the winner of the current tick.
    logic [pps_pkg::TIME_BITS-1:0] r_now;
    logic [pps_pkg::TIME_BITS-1:0] now_next;
    logic                          r_err;
    logic                          r_have;
    logic                          r_fin;
    logic [pps_pkg::IDX_W-1:0]     r_idx;
    logic [pps_pkg::TIME_BITS-1:0] r_arr;
    logic [pps_pkg::TIME_BITS-1:0] r_bst;
    logic [pps_pkg::TIME_BITS-1:0] r_tat;

    // Result registers.
    logic                               r_strobe;
    logic                               r_out_err;
    logic                               r_out_idle;
    logic [pps_pkg::FIELD_SLOT_W-1:0]   r_out_slot;
    logic                               r_out_fin;
    logic [pps_pkg::FIELD_TIME_W-1:0]   r_out_ft;
    logic [pps_pkg::FIELD_TIME_W-1:0]   r_out_tat;
    logic [pps_pkg::FIELD_TIME_W-1:0]   r_out_wt;
    logic                               r_out_all;
    logic [pps_pkg::FIELD_TIME_W-1:0]   r_out_time;

    logic                          accept;
    logic                          is_tick;
    logic                          burst_zero;
    logic                          serve;
    logic [pps_pkg::TIME_BITS-1:0] wait_diff;
    logic                          wait_ok;
    pps_pkg::t_load                load;
    pps_pkg::t_upd                 upd;
    logic                          chain_go;
    pps_pkg::t_cand                chain_cand;
    logic                          any_pending;

    assign busy       = (r_state != pps_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign is_tick    = (i_command == pps_pkg::CMD_TICK);
    assign burst_zero = (pps_pkg::TIME_BITS'(i_burst) == '0);

    assign load.en      = accept && !is_tick && !burst_zero;
    assign load.slot    = i_slot;
    assign load.arrival = pps_pkg::TIME_BITS'(i_arrival);
    assign load.prio    = pps_pkg::PRIO_BITS'(i_prio);
    assign load.burst   = pps_pkg::TIME_BITS'(i_burst);

    // The winner leaves the row in this cycle; it is served at the coming edge.
    assign serve    = (r_state == pps_pkg::ST_SCAN) && chain_go;
    assign upd.en   = serve && chain_cand.have;
    assign upd.idx  = chain_cand.idx;
    assign now_next = (r_now == pps_pkg::TIME_MAX) ? r_now : r_now + pps_pkg::TIME_BITS'(1);

    // Saturated time can leave the turnaround below the burst; waiting then reads zero.
    assign wait_ok   = (r_tat >= r_bst);
    assign wait_diff = r_tat - r_bst;

    pps_chain u_chain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_upd         (upd),
        .i_now         (r_now),
        .i_go          (accept && is_tick),
        .o_go          (chain_go),
        .o_cand        (chain_cand),
        .o_any_pending (any_pending)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pps_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = is_tick ? pps_pkg::ST_SCAN : pps_pkg::ST_LOAD;
                end
            end
            pps_pkg::ST_LOAD: n_state = pps_pkg::ST_IDLE;
            pps_pkg::ST_SCAN: begin
                if (chain_go) begin
                    n_state = pps_pkg::ST_TAT;
                end
            end
            pps_pkg::ST_TAT:  n_state = pps_pkg::ST_OUT;
            pps_pkg::ST_OUT:  n_state = pps_pkg::ST_IDLE;
            default:          n_state = pps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pps_pkg::ST_IDLE;
            r_now    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == pps_pkg::ST_LOAD) || (r_state == pps_pkg::ST_OUT);
            if (serve) begin
                r_now <= now_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err <= !is_tick && burst_zero;
        end
        if (serve) begin
            r_have <= chain_cand.have;
            r_fin  <= chain_cand.have && (chain_cand.rem <= pps_pkg::TIME_BITS'(1));
            r_idx  <= chain_cand.idx;
            r_arr  <= chain_cand.arrival;
            r_bst  <= chain_cand.burst;
        end
        if (r_state == pps_pkg::ST_TAT) begin
            r_tat <= r_now - r_arr;
        end
        if (r_state == pps_pkg::ST_LOAD) begin
            r_out_err  <= r_err;
            r_out_idle <= 1'b0;
            r_out_slot <= '0;
            r_out_fin  <= 1'b0;
            r_out_ft   <= '0;
            r_out_tat  <= '0;
            r_out_wt   <= '0;
            r_out_all  <= !any_pending;
            r_out_time <= pps_pkg::FIELD_TIME_W'(r_now);
        end else if (r_state == pps_pkg::ST_OUT) begin
            r_out_err  <= 1'b0;
            r_out_idle <= !r_have;
            r_out_slot <= r_have ? pps_pkg::FIELD_SLOT_W'(r_idx) : '0;
            r_out_fin  <= r_fin;
            r_out_ft   <= r_fin ? pps_pkg::FIELD_TIME_W'(r_now) : '0;
            r_out_tat  <= r_fin ? pps_pkg::FIELD_TIME_W'(r_tat) : '0;
            r_out_wt   <= (r_fin && wait_ok) ? pps_pkg::FIELD_TIME_W'(wait_diff) : '0;
            r_out_all  <= !any_pending;
            r_out_time <= pps_pkg::FIELD_TIME_W'(r_now);
        end
    end

    assign o_strobe       = r_strobe;
    assign o_load_error   = r_out_err;
    assign o_idle         = r_out_idle;
    assign o_running_slot = r_out_slot;
    assign o_finished     = r_out_fin;
    assign o_finish_time  = r_out_ft;
    assign o_turnaround   = r_out_tat;
    assign o_waiting      = r_out_wt;
    assign o_all_done     = r_out_all;
    assign o_tick_time    = r_out_time;

    `PPS_ASSERT_NXT(a_accept_busy, accept, busy, "accepted beat did not raise busy")
    `PPS_ASSERT_NXT(a_strobe_single, r_strobe, !r_strobe, "result strobe held two cycles")
    `PPS_ASSERT_IMP(a_idle_no_slot, r_strobe && r_out_idle, (r_out_slot == '0) && !r_out_fin, "idle tick reported a served slot")
    `PPS_ASSERT_IMP(a_err_is_load, r_strobe && r_out_err, !r_out_idle && !r_out_fin, "load error mixed with tick result")

endmodule
